>>> hw/rtl/rlfc_pkg.sv
// Package for the RGB LED fade controller: mode codes, operation codes,
// register indexes, widths and the controller/datapath command and status structs.
// No dependencies.
package rlfc_pkg;

	localparam int FracBits  = 16;
	localparam int LevelW    = 8 + FracBits;
	localparam int PowerFadeMs = 1500;
	// step numerator = elapsed(16) * target(8) << (FracBits+1)
	localparam int NumW      = 16 + 8 + FracBits + 1;
	localparam int QuoW      = NumW;
	localparam int CntW      = $clog2(NumW + 1);

	typedef enum logic [2:0] {
		MODE_OFF      = 3'd0,
		MODE_PWR_DOWN = 3'd1,
		MODE_PWR_UP   = 3'd2,
		MODE_SOLID    = 3'd3,
		MODE_FADE_IN  = 3'd4,
		MODE_FADE_OUT = 3'd5,
		MODE_RSVD6    = 3'd6,
		MODE_RSVD7    = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SOLID = 2'd1,
		OP_PWR_ON = 2'd2,
		OP_PWR_OFF = 2'd3
	} op_t;

	localparam logic [2:0] REG_FADE_TIME = 3'd0;
	localparam logic [2:0] REG_LAST      = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       load;     // start division for channel chan
		logic       step;     // one division step
		logic       apply;    // apply quotient to channel chan
		logic       up;       // upward move
		logic [1:0] chan;
		logic       clr_done; // set all-done flag before a sweep
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
		logic all_done;
	} dp_sts_t;

endpackage

>>> hw/rtl/rlfc_datapath.sv
// Datapath of the fade controller: channel levels and a shared
// restoring divider for the per-channel step. Uses rlfc_pkg.
module rlfc_datapath
	import rlfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic [15:0]          elapsed,
	input  logic [15:0]          period,
	input  logic [7:0]           target,
	input  logic                 set_levels,
	input  logic [3*8-1:0]       set_value,
	output dp_sts_t              sts,
	output logic [3*LevelW-1:0]  levels
);

	logic [LevelW-1:0] level_q [3];
	logic [NumW-1:0]   num_q;
	logic [16:0]       rem_q;
	logic [QuoW-1:0]   quo_q;
	logic [CntW-1:0]   cnt_q;
	logic              done_q;
	logic [16:0]       trial;
	logic [NumW-1:0]   prod;
	logic [NumW:0]     upv;
	logic [LevelW-1:0] tfix, nv;
	localparam logic [LevelW-1:0] LevelMax = {8'hff, {FracBits{1'b0}}};

	assign prod = {({8'd0, elapsed} * {16'd0, target}), {(FracBits + 1){1'b0}}};
	assign trial = {rem_q[15:0], num_q[NumW-1]};
	assign tfix = {target, {FracBits{1'b0}}};

	always_comb begin
		upv = (NumW+1)'(level_q[cmd.chan]);
		nv = level_q[cmd.chan];
		if (cmd.up) begin
			if (elapsed != 16'd0) begin
				upv = upv + (NumW+1)'(quo_q);
				nv = (upv > (NumW+1)'(LevelMax)) ? LevelMax : upv[LevelW-1:0];
			end
			if (nv >= tfix) nv = tfix;
		end else if (elapsed != 16'd0) begin
			nv = (quo_q >= QuoW'(level_q[cmd.chan])) ? '0
				: level_q[cmd.chan] - quo_q[LevelW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) level_q[c] <= '0;
			num_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.clr_done) done_q <= 1'b1;
			if (cmd.load) begin
				num_q <= prod;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CntW'(NumW);
			end else if (cmd.step) begin
				// restoring step: one quotient bit per cycle
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (trial >= {1'b0, period}) begin
					rem_q <= trial - {1'b0, period};
					quo_q <= {quo_q[QuoW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[QuoW-2:0], 1'b0};
				end
			end
			if (cmd.apply) begin
				level_q[cmd.chan] <= nv;
				if (cmd.up ? (nv != tfix) : (nv != '0)) done_q <= 1'b0;
			end
			if (set_levels) begin
				for (int c = 0; c < 3; c++)
					level_q[c] <= {set_value[c*8 +: 8], {FracBits{1'b0}}};
			end
		end
	end

	assign sts.div_last = (cnt_q == CntW'(1));
	assign sts.all_done = done_q;
	assign levels = {level_q[2], level_q[1], level_q[0]};

endmodule

>>> hw/rtl/rlfc_ctrl.sv
// Controller of the fade controller: handshake, mode bookkeeping and
// sequencing of the shared divider over three channels. Uses rlfc_pkg.
module rlfc_ctrl
	import rlfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [23:0] solid,
	input  logic [15:0] fade_period,
	input  logic [47:0] palette,
	input  dp_sts_t     sts,
	input  logic [3*LevelW-1:0] levels,
	output dp_cmd_t     cmd,
	output logic [15:0] period,
	output logic [7:0]  target,
	output logic        set_levels,
	output logic [23:0] set_value,
	output logic        res_valid,
	input  logic        out_stall,
	output mode_t       mode_q,
	output logic        sel_q
);

	state_t st_q, st_d;
	logic [1:0] ch_q, ch_d;
	logic resume_q, off_after_q;
	logic [23:0] saved_q;
	logic up, ramp;
	logic [23:0] pal;
	logic [23:0] ints;
	logic accept;

	assign accept = in_valid && !in_stall;
	assign ramp = (mode_q == MODE_PWR_UP) || (mode_q == MODE_PWR_DOWN);
	assign up = (mode_q == MODE_PWR_UP) || (mode_q == MODE_FADE_IN);
	assign pal = sel_q ? palette[47:24] : palette[23:0];
	assign period = ramp ? 16'(PowerFadeMs)
		: ((fade_period == 16'd0) ? 16'd1 : fade_period);
	assign target = ramp ? saved_q[ch_q*8 +: 8] : pal[ch_q*8 +: 8];
	for (genvar c = 0; c < 3; c++) begin : g_int
		assign ints[c*8 +: 8] = levels[c*LevelW + FracBits +: 8];
	end

	always_comb begin
		st_d = st_q;
		ch_d = ch_q;
		cmd = '0;
		cmd.chan = ch_q;
		cmd.up = up;
		in_stall = 1'b1;
		case (st_q)
			ST_IDLE: begin
				in_stall = res_valid && out_stall;
				if (accept && op == OP_TICK && (mode_q == MODE_PWR_UP ||
					mode_q == MODE_PWR_DOWN || mode_q == MODE_FADE_IN ||
					mode_q == MODE_FADE_OUT)) begin
					st_d = ST_LOAD;
					ch_d = 2'd0;
					cmd.clr_done = 1'b1;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				st_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) st_d = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				if (ch_q == 2'd2) st_d = ST_DONE;
				else begin
					ch_d = ch_q + 2'd1;
					st_d = ST_LOAD;
				end
			end
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// Load the solid colour, or black for a power-on ramp from the saved colour.
	assign set_value = (op == OP_SOLID) ? solid : 24'd0;
	assign set_levels = accept && (
		(op == OP_SOLID && mode_q != MODE_OFF && mode_q != MODE_PWR_DOWN) ||
		(op == OP_PWR_ON && resume_q && (mode_q == MODE_OFF || mode_q == MODE_PWR_DOWN)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ch_q <= '0;
			mode_q <= MODE_OFF;
			sel_q <= 1'b0;
			resume_q <= 1'b0;
			off_after_q <= 1'b0;
			saved_q <= '0;
			res_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			ch_q <= ch_d;
			if (res_valid && !out_stall) res_valid <= 1'b0;
			if (accept) begin
				case (op_t'(op))
					OP_TICK: if (st_d == ST_IDLE) res_valid <= 1'b1;
					OP_SOLID: begin
						resume_q <= 1'b1;
						saved_q <= solid;
						if (set_levels) begin
							mode_q <= MODE_SOLID;
							off_after_q <= 1'b0;
						end
						res_valid <= 1'b1;
					end
					OP_PWR_ON: begin
						if (mode_q == MODE_OFF || mode_q == MODE_PWR_DOWN) begin
							off_after_q <= 1'b0;
							mode_q <= resume_q ? MODE_PWR_UP : MODE_FADE_IN;
						end
						res_valid <= 1'b1;
					end
					OP_PWR_OFF: begin
						if (mode_q == MODE_SOLID) begin
							saved_q <= ints;
							resume_q <= 1'b1;
							mode_q <= MODE_PWR_DOWN;
						end else if (mode_q == MODE_PWR_UP) begin
							resume_q <= 1'b1;
							mode_q <= MODE_PWR_DOWN;
						end else if (mode_q == MODE_FADE_IN || mode_q == MODE_FADE_OUT) begin
							off_after_q <= 1'b1;
							resume_q <= 1'b0;
							mode_q <= MODE_FADE_OUT;
						end
						res_valid <= 1'b1;
					end
					default: res_valid <= 1'b1;
				endcase
			end
			if (st_q == ST_DONE) begin
				res_valid <= 1'b1;
				if (sts.all_done) begin
					case (mode_q)
						MODE_PWR_DOWN: mode_q <= MODE_OFF;
						MODE_PWR_UP: mode_q <= MODE_SOLID;
						MODE_FADE_IN: mode_q <= MODE_FADE_OUT;
						MODE_FADE_OUT: begin
							sel_q <= ~sel_q;
							off_after_q <= 1'b0;
							mode_q <= off_after_q ? MODE_OFF : MODE_FADE_IN;
						end
						default: mode_q <= mode_q;
					endcase
				end
			end
		end
	end

endmodule

>>> hw/rtl/rgb_led_fade_controller.sv
// RGB LED fade controller top level: configuration registers and the
// controller/datapath pair. Uses rlfc_pkg.
// Results: commands and ticks in off or solid give a result in the cycle after
// acceptance; a moving tick runs load, divide, apply per channel on the shared divider.
// Throughput: one transaction at a time; input stalls until its result has left.
// Reset (arst_n low) clears mode, levels and saved colour, registers to defaults.
module rgb_led_fade_controller
	import rlfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] elapsed_ms,
	input  logic [7:0]  solid_red,
	input  logic [7:0]  solid_green,
	input  logic [7:0]  solid_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  drive_red,
	output logic [7:0]  drive_green,
	output logic [7:0]  drive_blue,
	output logic [2:0]  mode_now,
	output logic        palette_index,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] fade_period_q;
	logic [7:0]  pal_q [6];
	logic [15:0] elapsed_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [15:0] period;
	logic [7:0]  target;
	logic        set_levels;
	logic [23:0] set_value;
	logic [3*LevelW-1:0] levels;
	mode_t       mode;
	logic        sel;

	// Configuration writes; indexes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_period_q <= 16'd3000;
			pal_q[0] <= 8'd0;   pal_q[1] <= 8'd0; pal_q[2] <= 8'd128;
			pal_q[3] <= 8'd128; pal_q[4] <= 8'd0; pal_q[5] <= 8'd116;
		end else if (cfg_we) begin
			if (cfg_index == REG_FADE_TIME) fade_period_q <= cfg_data;
			else if (cfg_index <= REG_LAST) pal_q[cfg_index - 3'd1] <= cfg_data[7:0];
		end
	end

	// Hold the elapsed time of the accepted tick for the whole sweep.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) elapsed_q <= elapsed_ms;
	end

	rlfc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall,
		.op(operation),
		.solid({solid_blue, solid_green, solid_red}),
		.fade_period(fade_period_q),
		.palette({pal_q[5], pal_q[4], pal_q[3], pal_q[2], pal_q[1], pal_q[0]}),
		.sts, .levels, .cmd, .period, .target, .set_levels, .set_value,
		.res_valid(out_valid), .out_stall,
		.mode_q(mode), .sel_q(sel)
	);

	rlfc_datapath u_dp (
		.clk, .arst_n, .cmd,
		.elapsed(elapsed_q), .period, .target, .set_levels, .set_value,
		.sts, .levels
	);

	// Result fields follow live state, which holds while a result waits.
	assign drive_red   = (mode == MODE_OFF) ? 8'd0 : levels[FracBits +: 8];
	assign drive_green = (mode == MODE_OFF) ? 8'd0 : levels[LevelW + FracBits +: 8];
	assign drive_blue  = (mode == MODE_OFF) ? 8'd0 : levels[2*LevelW + FracBits +: 8];
	assign mode_now = mode;
	assign palette_index = sel;

endmodule

>>> hw/rtl/rlfc_checker.sv
// Port-level checker for the fade controller, bound to the top level.
// Uses rlfc_pkg for mode codes.
module rlfc_checker
	import rlfc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] drive_red,
	input logic [7:0] drive_green,
	input logic [7:0] drive_blue,
	input logic [2:0] mode_now
);

	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_now == MODE_OFF |->
		drive_red == 8'd0 && drive_green == 8'd0 && drive_blue == 8'd0)
		else $error("drive not dark while off");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_now != 3'd6 && mode_now != 3'd7)
		else $error("unused mode code");

	a_no_take_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result waits");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mode_now))
		else $error("stalled result changed");

endmodule

bind rgb_led_fade_controller rlfc_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.drive_red, .drive_green, .drive_blue, .mode_now
);

>>> sim/rgb_led_fade_controller_checker.sv
// Scoreboard for the RGB LED fade controller: watches the configuration port
// and both channels, predicts each result from its own model of the block and
// compares it field by field. Depends on rlfc_pkg.
module rgb_led_fade_controller_checker
	import rlfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] elapsed_ms,
	input  logic [7:0]  solid_red,
	input  logic [7:0]  solid_green,
	input  logic [7:0]  solid_blue,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  drive_red,
	input  logic [7:0]  drive_green,
	input  logic [7:0]  drive_blue,
	input  logic [2:0]  mode_now,
	input  logic        palette_index,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] mode;
		logic       pal;
	} drive_t;

	localparam logic [63:0] LevelTop = 64'd255 << FracBits;

	drive_t      drive_q[$];
	logic [15:0] period_ms;
	logic [7:0]  palette [2][3];
	mode_t       mode;
	logic        resume_solid, off_after_fade, sel;
	logic [63:0] level [3];
	logic [7:0]  saved [3];

	function automatic logic [63:0] rate(logic [15:0] el, logic [7:0] tgt, logic [15:0] per);
		logic [63:0] p;
		p = (per == 16'd0) ? 64'd1 : {48'd0, per};
		return ({48'd0, el} * ({56'd0, tgt} << FracBits) * 64'd2) / p;
	endfunction

	// Raise the levels toward tgt; report whether all have arrived.
	function automatic logic ramp_up(logic [7:0] tgt [3], logic [15:0] el, logic [15:0] per);
		logic        done;
		logic [63:0] t, v;
		done = 1'b1;
		for (int c = 0; c < 3; c++) begin
			t = {56'd0, tgt[c]} << FracBits;
			v = level[c];
			if (el != 0) begin
				v = v + rate(el, tgt[c], per);
				if (v > LevelTop) v = LevelTop;
			end
			if (v >= t) v = t;
			level[c] = v;
			if (v != t) done = 1'b0;
		end
		return done;
	endfunction

	// Lower the levels at the rate of tgt; report whether all reached zero.
	function automatic logic ramp_down(logic [7:0] tgt [3], logic [15:0] el, logic [15:0] per);
		logic        done;
		logic [63:0] d;
		done = 1'b1;
		for (int c = 0; c < 3; c++) begin
			if (el != 0) begin
				d = rate(el, tgt[c], per);
				level[c] = (d >= level[c]) ? 64'd0 : level[c] - d;
			end
			if (level[c] != 0) done = 1'b0;
		end
		return done;
	endfunction

	task automatic predict_item();
		drive_t      exp_d;
		logic [7:0]  pal [3];
		logic [7:0]  col [3];
		logic [15:0] el;
		el = elapsed_ms;
		col = '{solid_red, solid_green, solid_blue};
		pal = palette[sel];
		case (op_t'(operation))
			OP_TICK: case (mode)
				MODE_PWR_DOWN: if (ramp_down(saved, el, 16'(PowerFadeMs))) mode = MODE_OFF;
				MODE_PWR_UP:   if (ramp_up(saved, el, 16'(PowerFadeMs))) mode = MODE_SOLID;
				MODE_FADE_IN:  if (ramp_up(pal, el, period_ms)) mode = MODE_FADE_OUT;
				MODE_FADE_OUT: if (ramp_down(pal, el, period_ms)) begin
					sel = ~sel;
					if (off_after_fade) begin
						off_after_fade = 1'b0;
						mode = MODE_OFF;
					end else begin
						mode = MODE_FADE_IN;
					end
				end
				default: ;
			endcase
			OP_SOLID: begin
				resume_solid = 1'b1;
				saved = col;
				if (mode != MODE_OFF && mode != MODE_PWR_DOWN) begin
					mode = MODE_SOLID;
					off_after_fade = 1'b0;
					for (int c = 0; c < 3; c++) level[c] = {56'd0, col[c]} << FracBits;
				end
			end
			OP_PWR_ON: if (mode == MODE_OFF || mode == MODE_PWR_DOWN) begin
				off_after_fade = 1'b0;
				if (resume_solid) begin
					for (int c = 0; c < 3; c++) level[c] = 64'd0;
					mode = MODE_PWR_UP;
				end else begin
					mode = MODE_FADE_IN;
				end
			end
			default: begin
				if (mode == MODE_SOLID) begin
					for (int c = 0; c < 3; c++) saved[c] = level[c][FracBits +: 8];
					resume_solid = 1'b1;
					mode = MODE_PWR_DOWN;
				end else if (mode == MODE_PWR_UP) begin
					resume_solid = 1'b1;
					mode = MODE_PWR_DOWN;
				end else if (mode == MODE_FADE_IN || mode == MODE_FADE_OUT) begin
					off_after_fade = 1'b1;
					resume_solid = 1'b0;
					mode = MODE_FADE_OUT;
				end
			end
		endcase
		exp_d.red   = (mode == MODE_OFF) ? 8'd0 : level[0][FracBits +: 8];
		exp_d.green = (mode == MODE_OFF) ? 8'd0 : level[1][FracBits +: 8];
		exp_d.blue  = (mode == MODE_OFF) ? 8'd0 : level[2][FracBits +: 8];
		exp_d.mode  = mode;
		exp_d.pal   = sel;
		drive_q.push_back(exp_d);
	endtask

	task automatic compare_result();
		drive_t e;
		if (drive_q.size() == 0) begin
			$error("result with no transaction outstanding");
			fail_count++;
			return;
		end
		e = drive_q.pop_front();
		if (drive_red !== e.red) begin
			$error("drive_red expected %0d got %0d", e.red, drive_red);
			fail_count++;
		end
		if (drive_green !== e.green) begin
			$error("drive_green expected %0d got %0d", e.green, drive_green);
			fail_count++;
		end
		if (drive_blue !== e.blue) begin
			$error("drive_blue expected %0d got %0d", e.blue, drive_blue);
			fail_count++;
		end
		if (mode_now !== e.mode) begin
			$error("mode_now expected %0d got %0d", e.mode, mode_now);
			fail_count++;
		end
		if (palette_index !== e.pal) begin
			$error("palette_index expected %0d got %0d", e.pal, palette_index);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ms      <= 16'd3000;
			palette        <= '{'{8'd0, 8'd0, 8'd128}, '{8'd128, 8'd0, 8'd116}};
			mode           <= MODE_OFF;
			resume_solid   <= 1'b0;
			off_after_fade <= 1'b0;
			sel            <= 1'b0;
			level          <= '{64'd0, 64'd0, 64'd0};
			saved          <= '{8'd0, 8'd0, 8'd0};
			fail_count     <= 0;
			results_seen   <= 0;
			drive_q.delete();
		end else begin
			// compare first: a result can never belong to a transaction taken this edge
			if (out_valid && !out_stall) begin
				compare_result();
				results_seen++;
			end
			if (in_valid && !in_stall) predict_item();
			if (cfg_we) begin
				if (cfg_index == REG_FADE_TIME)
					period_ms = cfg_data;
				else if (cfg_index <= REG_LAST)
					palette[(cfg_index - 1) / 3][(cfg_index - 1) % 3] = cfg_data[7:0];
			end
		end
	end

	assign pending = drive_q.size();

endmodule

>>> sim/rgb_led_fade_controller_tb.sv
// Testbench top for the RGB LED fade controller: clock, reset, stimulus,
// receiver back-pressure and the verdict. Depends on rlfc_pkg, the block and
// rgb_led_fade_controller_checker.
module rgb_led_fade_controller_tb;
	import rlfc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 2_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_TICK;
	logic [15:0] elapsed_ms = '0;
	logic [7:0]  solid_red = '0, solid_green = '0, solid_blue = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  drive_red, drive_green, drive_blue;
	logic [2:0]  mode_now;
	logic        palette_index;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int fail_count, pending, results_seen;
	int sent = 0;        // transactions accepted so far
	int burst_left = 0;
	int cyc = 0;
	bit held_off = 1'b0; // the long receiver hold-off has happened

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rgb_led_fade_controller uut (.*);

	rgb_led_fade_controller_checker chk (.*);

	// Watchdog: give up well past the slowest legal run.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver back-pressure: a stall density of 0, 35 or 70 percent that is redrawn
	// as the run goes on, and once, a long hold-off so that the block backs up into its input.
	always @(posedge clk) begin
		static int pct = 0;
		static int hold = 0;
		if (cyc % 200 == 0) pct = $urandom_range(0, 2) * 35;
		if (!held_off && sent >= 400) begin
			held_off <= 1'b1;
			hold = 3000;
		end
		if (hold > 0) begin
			hold--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < pct);
		end
	end

	// Offer one transaction and hold it until taken; then maybe drop valid for
	// a gap when the current burst runs out.
	task automatic send(op_t op, logic [15:0] el, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		in_valid    <= 1'b1;
		operation   <= op;
		elapsed_ms  <= el;
		solid_red   <= r;
		solid_green <= g;
		solid_blue  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 3))
					@(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Drain everything outstanding so registers can be written while idle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write enable stays up across a run of writes; the caller drops it.
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Random transaction: mostly ticks with short steps so fades run their
	// course, with commands mixed in and the odd huge or zero step.
	task automatic send_random();
		int          pick;
		logic [15:0] el;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 19))
			0:       el = 16'd0;
			1, 2:    el = 16'($urandom_range(0, 65535));
			3, 4, 5: el = 16'($urandom_range(0, 2000));
			default: el = 16'($urandom_range(0, 60));
		endcase
		send(pick < 70 ? OP_TICK : pick < 80 ? OP_SOLID : pick < 90 ? OP_PWR_ON : OP_PWR_OFF,
			el, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		logic [15:0] ft;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default palette and period, walk every mode and command.
		send(OP_TICK, 16'd0, 8'd0, 8'd0, 8'd0);          // off: tick is inert
		send(OP_PWR_OFF, 16'd10, 8'd0, 8'd0, 8'd0);      // off: ignored
		send(OP_PWR_ON, 16'd0, 8'd0, 8'd0, 8'd0);        // resume fading
		send(OP_PWR_ON, 16'd0, 8'd0, 8'd0, 8'd0);        // already on: ignored
		send(OP_TICK, 16'd0, 8'd0, 8'd0, 8'd0);          // zero step still tests completion
		send(OP_TICK, 16'd1500, 8'd0, 8'd0, 8'd0);       // reach target in one step
		send(OP_TICK, 16'd1, 8'd0, 8'd0, 8'd0);          // fade out starts
		send(OP_TICK, 16'd65535, 8'd0, 8'd0, 8'd0);      // floor at zero, palette flips
		send(OP_TICK, 16'd65535, 8'd0, 8'd0, 8'd0);      // clamp at top
		send(OP_PWR_OFF, 16'd0, 8'd0, 8'd0, 8'd0);       // fade out then off
		send(OP_TICK, 16'd65535, 8'd0, 8'd0, 8'd0);
		send(OP_TICK, 16'd65535, 8'd0, 8'd0, 8'd0);
		send(OP_SOLID, 16'd0, 8'd255, 8'd255, 8'd255);   // saved only, still off
		send(OP_PWR_ON, 16'd0, 8'd0, 8'd0, 8'd0);        // ramp up from black
		send(OP_TICK, 16'd100, 8'd0, 8'd0, 8'd0);
		send(OP_PWR_OFF, 16'd0, 8'd0, 8'd0, 8'd0);       // reverse mid ramp
		send(OP_TICK, 16'd50, 8'd0, 8'd0, 8'd0);
		send(OP_PWR_ON, 16'd0, 8'd0, 8'd0, 8'd0);        // restart from powering off
		send(OP_TICK, 16'd65535, 8'd0, 8'd0, 8'd0);      // lands in solid
		send(OP_SOLID, 16'd65535, 8'd0, 8'd0, 8'd0);
		send(OP_SOLID, 16'd0, 8'd255, 8'd170, 8'd85);
		send(OP_TICK, 16'd7, 8'd0, 8'd0, 8'd0);          // solid: unchanged
		send(OP_PWR_OFF, 16'd0, 8'd0, 8'd0, 8'd0);       // solid to powering off
		send(OP_PWR_OFF, 16'd0, 8'd0, 8'd0, 8'd0);       // ignored
		send(OP_TICK, 16'd65535, 8'd0, 8'd0, 8'd0);      // lands in off
		drain();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       ft = 16'd1;
				1:       ft = 16'd65535;
				2:       ft = 16'd0;
				3:       ft = 16'd3000;
				default: ft = 16'($urandom_range(2, 400));
			endcase
			write_reg(REG_FADE_TIME, ft);
			for (int i = 1; i <= REG_LAST; i++)
				write_reg(3'(i), ph == 1 ? 16'hFFFF : ph == 2 ? 16'hFF00 : 16'($urandom));
			write_reg(3'd7, 16'($urandom));            // unmapped index: ignored
			cfg_we <= 1'b0;
			repeat (ph == 1 ? 60 : 250) send_random();
			drain();
		end

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		$display("Covered %0d transactions and %0d results over 9 register settings,", sent,
			results_seen);
		$display("including a long receiver hold-off and unmapped register writes.");
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
